// File: rtl/core/esckd_pkg.sv
// ----------------------------------------------------------------------------
// esckd_pkg
// Types, character constants and key codes shared by the escape key decoder.
// ----------------------------------------------------------------------------
package esckd_pkg;

	// Characters recognized by the parser
	localparam logic [7:0] CH_ESC   = 8'h1b;
	localparam logic [7:0] CH_LBRKT = 8'h5b;  // '['
	localparam logic [7:0] CH_TILDE = 8'h7e;  // '~'
	localparam logic [7:0] CH_0     = 8'h30;  // '0'
	localparam logic [7:0] CH_9     = 8'h39;  // '9'
	localparam logic [7:0] CH_A     = 8'h41;  // 'A'
	localparam logic [7:0] CH_B     = 8'h42;  // 'B'
	localparam logic [7:0] CH_C     = 8'h43;  // 'C'
	localparam logic [7:0] CH_D     = 8'h44;  // 'D'
	localparam logic [7:0] CH_H     = 8'h48;  // 'H'
	localparam logic [7:0] CH_F     = 8'h46;  // 'F'

	// Key codes
	localparam logic [8:0] KEY_NONE  = 9'd0;
	localparam logic [8:0] KEY_ESC   = 9'd27;
	localparam logic [8:0] KEY_UP    = 9'd256;
	localparam logic [8:0] KEY_DOWN  = 9'd257;
	localparam logic [8:0] KEY_RIGHT = 9'd258;
	localparam logic [8:0] KEY_LEFT  = 9'd259;
	localparam logic [8:0] KEY_HOME  = 9'd260;
	localparam logic [8:0] KEY_END   = 9'd261;
	localparam logic [8:0] KEY_DEL   = 9'd262;
	localparam logic [8:0] KEY_PGUP  = 9'd263;
	localparam logic [8:0] KEY_PGDN  = 9'd264;

	// Tilde sequence digits
	localparam logic [3:0] DIG_HOME = 4'd1;
	localparam logic [3:0] DIG_DEL  = 4'd3;
	localparam logic [3:0] DIG_END  = 4'd4;
	localparam logic [3:0] DIG_PGUP = 4'd5;
	localparam logic [3:0] DIG_PGDN = 4'd6;

	// Output queue geometry
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_ESC   = 4'b0010,
		PH_CSI   = 4'b0100,
		PH_DIGIT = 4'b1000
	} esckd_phase_t;

	// One input byte event
	typedef struct packed {
		logic       no_byte;
		logic [7:0] byte_value;
	} esckd_item_t;

	// Results caused by one item: cnt of 0, 1 or 2 codes
	typedef struct packed {
		logic [1:0] cnt;
		logic [8:0] code0;
		logic [8:0] code1;
	} esckd_res_t;

	// One queued result item
	typedef struct packed {
		logic       last;
		logic [8:0] key_code;
	} esckd_ent_t;

	function automatic logic [8:0] csi_letter(input logic [7:0] b);
		logic [8:0] k;
		case (b)
			CH_A:    k = KEY_UP;
			CH_B:    k = KEY_DOWN;
			CH_C:    k = KEY_RIGHT;
			CH_D:    k = KEY_LEFT;
			CH_H:    k = KEY_HOME;
			CH_F:    k = KEY_END;
			default: k = KEY_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [8:0] csi_tilde(input logic [3:0] d);
		logic [8:0] k;
		case (d)
			DIG_HOME: k = KEY_HOME;
			DIG_DEL:  k = KEY_DEL;
			DIG_END:  k = KEY_END;
			DIG_PGUP: k = KEY_PGUP;
			DIG_PGDN: k = KEY_PGDN;
			default:  k = KEY_NONE;
		endcase
		return k;
	endfunction

endpackage

// File: rtl/core/escape_sequence_key_decoder.sv
// ----------------------------------------------------------------------------
// escape_sequence_key_decoder
// Turns a stream of terminal bytes into key codes (arrows, home, end, ...).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_axis: one terminal byte per item in tdata[7:0]; tuser
//   set means the read failed and no byte is present (gives ESC, resets
//   the parser).
//   Output channel m_axis: one key code per item in tdata[8:0]; codes 0-255
//   are bytes, 256-264 are up, down, right, left, home, end, delete,
//   page up, page down. tlast marks the final key caused by one input byte.
//   An input byte causes zero, one or two output items.
// Timing:
//   A byte is held in the input register, decoded and written into the
//   result queue when it has room; its first key is offered from the queue
//   head. One byte is taken per cycle while the queue has room; a byte that
//   yields two keys gives them out one after the other, and the 4-entry
//   result queue absorbs that.
// Reset:
//   arst_n clears the parser to idle and empties the queue; no clearing pass.
// Stall:
//   While m_axis_tready is low, results wait in the queue; s_axis_tready
//   drops once the queue cannot take two more results and the input
//   register is full, and rises again as keys drain.
// ----------------------------------------------------------------------------
module escape_sequence_key_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
	input  logic        s_axis_tuser,   // [0] no_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [8:0] key_code, [15:9] zero
	output logic        m_axis_tlast
);

	logic                  valid_s1;
	esckd_pkg::esckd_item_t item_s1;
	esckd_pkg::esckd_res_t  res;
	esckd_pkg::esckd_ent_t  out_ent;
	logic                  room;
	logic                  adv;
	logic                  load;

	// advance the registered byte into the parser when the queue has room
	assign adv           = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;
	assign load          = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// hold the payload until it is decoded
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= '{no_byte: s_axis_tuser, byte_value: s_axis_tdata};
		end
	end

	esckd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.res    (res)
	);

	esckd_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv),
		.res       (res),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_ent   (out_ent)
	);

	assign m_axis_tdata = {7'd0, out_ent.key_code};
	assign m_axis_tlast = out_ent.last;

endmodule

// File: rtl/core/esckd_parser.sv
// ----------------------------------------------------------------------------
// esckd_parser
// Parse phase and held digit; decodes one registered item into its results.
// ----------------------------------------------------------------------------
module esckd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  esckd_pkg::esckd_item_t item,
	output esckd_pkg::esckd_res_t  res
);

	esckd_pkg::esckd_phase_t phase_q, phase_d;
	logic [3:0] held_digit_q, held_digit_d;
	logic [7:0] b;
	logic [7:0] dig;

	assign b   = item.byte_value;
	assign dig = b - esckd_pkg::CH_0;

	always_comb begin
		phase_d      = phase_q;
		held_digit_d = held_digit_q;
		res.cnt      = 2'd0;
		res.code0    = esckd_pkg::KEY_NONE;
		res.code1    = esckd_pkg::KEY_NONE;
		if (item.no_byte) begin
			phase_d   = esckd_pkg::PH_IDLE;
			res.cnt   = 2'd1;
			res.code0 = esckd_pkg::KEY_ESC;
		end else begin
			case (phase_q)
				esckd_pkg::PH_IDLE: begin
					if (b == esckd_pkg::CH_ESC) begin
						phase_d = esckd_pkg::PH_ESC;
					end else begin
						res.cnt   = 2'd1;
						res.code0 = {1'b0, b};
					end
				end
				esckd_pkg::PH_ESC: begin
					if (b == esckd_pkg::CH_LBRKT) begin
						phase_d = esckd_pkg::PH_CSI;
					end else if (b == esckd_pkg::CH_ESC) begin
						// give the first ESC, the second one opens a new sequence
						res.cnt   = 2'd1;
						res.code0 = esckd_pkg::KEY_ESC;
					end else begin
						phase_d   = esckd_pkg::PH_IDLE;
						res.cnt   = 2'd2;
						res.code0 = esckd_pkg::KEY_ESC;
						res.code1 = {1'b0, b};
					end
				end
				esckd_pkg::PH_CSI: begin
					if (b inside {[esckd_pkg::CH_0:esckd_pkg::CH_9]}) begin
						phase_d      = esckd_pkg::PH_DIGIT;
						held_digit_d = dig[3:0];
					end else begin
						phase_d   = esckd_pkg::PH_IDLE;
						res.cnt   = 2'd1;
						res.code0 = esckd_pkg::csi_letter(b);
					end
				end
				esckd_pkg::PH_DIGIT: begin
					phase_d   = esckd_pkg::PH_IDLE;
					res.cnt   = 2'd1;
					res.code0 = (b == esckd_pkg::CH_TILDE) ?
					            esckd_pkg::csi_tilde(held_digit_q) : esckd_pkg::KEY_NONE;
				end
				default: begin
					phase_d = esckd_pkg::PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= esckd_pkg::PH_IDLE;
			held_digit_q <= 4'd0;
		end else if (adv) begin
			phase_q      <= phase_d;
			held_digit_q <= held_digit_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_pair_starts_esc: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.cnt == 2'd2 |-> res.code0 == esckd_pkg::KEY_ESC)
		else $error("two-result item does not start with ESC");
	a_miss_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item.no_byte |-> res.cnt == 2'd1)
		else $error("missing byte did not give exactly one result");
	a_miss_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item.no_byte |=> phase_q == esckd_pkg::PH_IDLE)
		else $error("missing byte did not return parser to idle");
`endif

endmodule

// File: rtl/core/esckd_outq.sv
// ----------------------------------------------------------------------------
// esckd_outq
// Small result queue: takes up to two results per cycle, gives one while out_ready is high.
// ----------------------------------------------------------------------------
module esckd_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  esckd_pkg::esckd_res_t res,
	output logic                  room,
	output logic                  out_valid,
	input  logic                  out_ready,
	output esckd_pkg::esckd_ent_t out_ent
);

	esckd_pkg::esckd_ent_t mem_q [esckd_pkg::OQ_DEPTH];
	logic [esckd_pkg::OQ_AW-1:0] wr_q, rd_q, wr1;
	logic [esckd_pkg::OQ_CW-1:0] count_q;
	logic [esckd_pkg::OQ_CW-1:0] n_push;
	logic pop;

	assign n_push    = push ? esckd_pkg::OQ_CW'(res.cnt) : '0;
	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_ent   = mem_q[rd_q];
	// room for the largest burst an item can cause
	assign room      = (count_q <= esckd_pkg::OQ_CW'(esckd_pkg::OQ_DEPTH - 2));
	assign wr1       = wr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push && res.cnt != 2'd0) begin
			mem_q[wr_q] <= '{last: (res.cnt == 2'd1), key_code: res.code0};
		end
		if (push && res.cnt == 2'd2) begin
			mem_q[wr1] <= '{last: 1'b1, key_code: res.code1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + esckd_pkg::OQ_AW'(n_push);
			rd_q    <= rd_q + esckd_pkg::OQ_AW'(pop);
			count_q <= count_q + n_push - esckd_pkg::OQ_CW'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= esckd_pkg::OQ_CW'(esckd_pkg::OQ_DEPTH))
		else $error("result queue overflow");
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room)
		else $error("push without room");
	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		pop && n_push == '0 |=> count_q == $past(count_q) - 1'b1)
		else $error("pop did not drain one entry");
`endif

endmodule

// File: test/escape_sequence_key_decoder_tb.sv
// ----------------------------------------------------------------------------
// escape_sequence_key_decoder_tb
// Self-checking bench for the terminal escape key decoder. Terminal bytes
// and missed reads go in on the input stream. A behavioral decoder, kept in
// step with every accepted input item, predicts the key codes, and each
// key on the output stream is compared with the oldest prediction. Both
// sides of the stream stall at random.
// ----------------------------------------------------------------------------
module escape_sequence_key_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT  = 4000; // cycles with no accepted item before giving up
	localparam int TAIL_CYCLES = 8;    // slack for keys still in flight at the end
	localparam int PRINT_LIMIT = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] byte_value
	logic        s_axis_tuser = 1'b0;    // [0] no_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;           // [8:0] key_code, [15:9] zero
	logic        m_axis_tlast;

	// Predicted decoder state
	esckd_pkg::esckd_phase_t decode_phase = esckd_pkg::PH_IDLE;
	logic [3:0]              decode_digit = 4'd0;
	esckd_pkg::esckd_ent_t   pending_keys[$];

	int mismatch_count = 0;
	int bytes_sent     = 0;
	int idle_cycles    = 0;
	int src_gap_pct    = 0;
	int rcv_gap_pct    = 0;

	escape_sequence_key_decoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Key prediction
	// ------------------------------------------------------------------------
	function automatic logic [8:0] letter_key(input logic [7:0] b);
		if (b == esckd_pkg::CH_A) return esckd_pkg::KEY_UP;
		if (b == esckd_pkg::CH_B) return esckd_pkg::KEY_DOWN;
		if (b == esckd_pkg::CH_C) return esckd_pkg::KEY_RIGHT;
		if (b == esckd_pkg::CH_D) return esckd_pkg::KEY_LEFT;
		if (b == esckd_pkg::CH_H) return esckd_pkg::KEY_HOME;
		if (b == esckd_pkg::CH_F) return esckd_pkg::KEY_END;
		return esckd_pkg::KEY_NONE;
	endfunction

	function automatic logic [8:0] tilde_key(input logic [3:0] d);
		if (d == esckd_pkg::DIG_HOME) return esckd_pkg::KEY_HOME;
		if (d == esckd_pkg::DIG_DEL)  return esckd_pkg::KEY_DEL;
		if (d == esckd_pkg::DIG_END)  return esckd_pkg::KEY_END;
		if (d == esckd_pkg::DIG_PGUP) return esckd_pkg::KEY_PGUP;
		if (d == esckd_pkg::DIG_PGDN) return esckd_pkg::KEY_PGDN;
		return esckd_pkg::KEY_NONE;
	endfunction

	function automatic void push_key(input logic [8:0] code, input logic fin);
		esckd_pkg::esckd_ent_t e;
		e.key_code = code;
		e.last     = fin;
		pending_keys.push_back(e);
	endfunction

	// Advance the predicted parser by one accepted input item
	function automatic void decode_byte(input logic [7:0] b, input logic nb);
		if (nb) begin
			// a missed read flushes whatever was pending as a bare ESC
			decode_phase = esckd_pkg::PH_IDLE;
			push_key(esckd_pkg::KEY_ESC, 1'b1);
		end else begin
			case (decode_phase)
				esckd_pkg::PH_ESC: begin
					if (b == esckd_pkg::CH_LBRKT) begin
						decode_phase = esckd_pkg::PH_CSI;
					end else if (b == esckd_pkg::CH_ESC) begin
						// give the old ESC, the new one opens a fresh sequence
						push_key(esckd_pkg::KEY_ESC, 1'b1);
					end else begin
						decode_phase = esckd_pkg::PH_IDLE;
						push_key(esckd_pkg::KEY_ESC, 1'b0);
						push_key({1'b0, b}, 1'b1);
					end
				end
				esckd_pkg::PH_CSI: begin
					if (b >= esckd_pkg::CH_0 && b <= esckd_pkg::CH_9) begin
						decode_digit = 4'(b - esckd_pkg::CH_0);
						decode_phase = esckd_pkg::PH_DIGIT;
					end else begin
						decode_phase = esckd_pkg::PH_IDLE;
						push_key(letter_key(b), 1'b1);
					end
				end
				esckd_pkg::PH_DIGIT: begin
					decode_phase = esckd_pkg::PH_IDLE;
					push_key((b == esckd_pkg::CH_TILDE) ?
						tilde_key(decode_digit) : esckd_pkg::KEY_NONE, 1'b1);
				end
				default: begin
					if (b == esckd_pkg::CH_ESC) begin
						decode_phase = esckd_pkg::PH_ESC;
					end else begin
						push_key({1'b0, b}, 1'b1);
					end
				end
			endcase
		end
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------------
	// Monitor: predict on every accepted input item, check every key
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		esckd_pkg::esckd_ent_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				decode_byte(s_axis_tdata, s_axis_tuser);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_keys.size() == 0) begin
					report_mismatch($sformatf("key %0d with none expected",
						m_axis_tdata[8:0]));
				end else begin
					want = pending_keys.pop_front();
					if (m_axis_tdata[8:0] !== want.key_code) begin
						report_mismatch($sformatf("key_code %0d, expected %0d",
							m_axis_tdata[8:0], want.key_code));
					end
					if (m_axis_tdata[15:9] !== 7'd0) begin
						report_mismatch($sformatf("tdata pad bits %h not zero",
							m_axis_tdata[15:9]));
					end
					if (m_axis_tlast !== want.last) begin
						report_mismatch($sformatf("tlast %b, expected %b (key %0d)",
							m_axis_tlast, want.last, want.key_code));
					end
				end
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver: stall at random
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rcv_gap_pct);
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic send_byte(input logic [7:0] b, input logic nb);
		while ($urandom_range(99) < src_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= nb;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		bytes_sent++;
	endtask

	// Hold off the sender until every predicted key has come out
	task automatic wait_keys_drained();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_keys.size() != 0) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_letter();
		case ($urandom_range(5))
			0:       return esckd_pkg::CH_A;
			1:       return esckd_pkg::CH_B;
			2:       return esckd_pkg::CH_C;
			3:       return esckd_pkg::CH_D;
			4:       return esckd_pkg::CH_H;
			default: return esckd_pkg::CH_F;
		endcase
	endfunction

	function automatic logic [7:0] pick_key_digit();
		case ($urandom_range(4))
			0:       return esckd_pkg::CH_0 + 8'(esckd_pkg::DIG_HOME);
			1:       return esckd_pkg::CH_0 + 8'(esckd_pkg::DIG_DEL);
			2:       return esckd_pkg::CH_0 + 8'(esckd_pkg::DIG_END);
			3:       return esckd_pkg::CH_0 + 8'(esckd_pkg::DIG_PGUP);
			default: return esckd_pkg::CH_0 + 8'(esckd_pkg::DIG_PGDN);
		endcase
	endfunction

	function automatic logic [7:0] any_digit();
		return esckd_pkg::CH_0 + 8'($urandom_range(9));
	endfunction

	// One random sequence: mostly well-formed escapes, some noise
	task automatic send_random_sequence();
		int kind;
		int n;
		kind = $urandom_range(99);
		if (kind < 30) begin
			send_byte(esckd_pkg::CH_ESC, 1'b0);
			send_byte(esckd_pkg::CH_LBRKT, 1'b0);
			send_byte(($urandom_range(99) < 80) ? pick_letter() : 8'($urandom()), 1'b0);
		end else if (kind < 60) begin
			send_byte(esckd_pkg::CH_ESC, 1'b0);
			send_byte(esckd_pkg::CH_LBRKT, 1'b0);
			send_byte(($urandom_range(99) < 70) ? pick_key_digit() : any_digit(), 1'b0);
			send_byte(($urandom_range(99) < 80) ? esckd_pkg::CH_TILDE : 8'($urandom()),
				1'b0);
		end else if (kind < 70) begin
			send_byte(8'($urandom()), 1'b0);
		end else if (kind < 78) begin
			send_byte(esckd_pkg::CH_ESC, 1'b0);
			send_byte(8'($urandom()), 1'b0);
		end else if (kind < 88) begin
			// sequence cut short by a missed read
			n = $urandom_range(1, 3);
			send_byte(esckd_pkg::CH_ESC, 1'b0);
			if (n > 1) send_byte(esckd_pkg::CH_LBRKT, 1'b0);
			if (n > 2) send_byte(any_digit(), 1'b0);
			send_byte(8'($urandom()), 1'b1);
		end else if (kind < 94) begin
			send_byte(8'($urandom()), 1'b1);
		end else begin
			// broken run of sequence characters
			n = $urandom_range(1, 4);
			repeat (n) begin
				case ($urandom_range(3))
					0:       send_byte(esckd_pkg::CH_ESC, 1'b0);
					1:       send_byte(esckd_pkg::CH_LBRKT, 1'b0);
					2:       send_byte(esckd_pkg::CH_TILDE, 1'b0);
					default: send_byte(any_digit(), 1'b0);
				endcase
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_directed();
		src_gap_pct = 0;
		rcv_gap_pct = 0;
		// plain byte extremes, then a missed read in idle
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b1);
		// arrow key
		send_byte(esckd_pkg::CH_ESC, 1'b0);
		send_byte(esckd_pkg::CH_LBRKT, 1'b0);
		send_byte(esckd_pkg::CH_A, 1'b0);
		// page up via tilde
		send_byte(esckd_pkg::CH_ESC, 1'b0);
		send_byte(esckd_pkg::CH_LBRKT, 1'b0);
		send_byte(esckd_pkg::CH_0 + 8'(esckd_pkg::DIG_PGUP), 1'b0);
		send_byte(esckd_pkg::CH_TILDE, 1'b0);
		// unknown digit before tilde
		send_byte(esckd_pkg::CH_ESC, 1'b0);
		send_byte(esckd_pkg::CH_LBRKT, 1'b0);
		send_byte(esckd_pkg::CH_0, 1'b0);
		send_byte(esckd_pkg::CH_TILDE, 1'b0);
		// digit not closed by tilde
		send_byte(esckd_pkg::CH_ESC, 1'b0);
		send_byte(esckd_pkg::CH_LBRKT, 1'b0);
		send_byte(esckd_pkg::CH_0 + 8'(esckd_pkg::DIG_DEL), 1'b0);
		send_byte(8'h71, 1'b0);
		// ESC after ESC, then ESC plus a plain byte gives two keys
		send_byte(esckd_pkg::CH_ESC, 1'b0);
		send_byte(esckd_pkg::CH_ESC, 1'b0);
		send_byte(8'h61, 1'b0);
		// missed read in every sequence phase
		send_byte(esckd_pkg::CH_ESC, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(esckd_pkg::CH_ESC, 1'b0);
		send_byte(esckd_pkg::CH_LBRKT, 1'b0);
		send_byte(8'h5a, 1'b1);
		send_byte(esckd_pkg::CH_ESC, 1'b0);
		send_byte(esckd_pkg::CH_LBRKT, 1'b0);
		send_byte(esckd_pkg::CH_0 + 8'(esckd_pkg::DIG_PGDN), 1'b0);
		send_byte(8'hff, 1'b1);
		wait_keys_drained();
	endtask

	task automatic test_random(input int n_bytes, input int src_pct, input int rcv_pct);
		int start;
		bit paused;
		start       = bytes_sent;
		paused      = 1'b0;
		src_gap_pct = src_pct;
		rcv_gap_pct = rcv_pct;
		while (bytes_sent - start < n_bytes) begin
			send_random_sequence();
			if (!paused && bytes_sent - start >= n_bytes / 2) begin
				wait_keys_drained();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random(310, 37, 68);
		test_random(310, 68, 37);
		test_random(310, 0, 0);

		wait_keys_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (pending_keys.size() != 0) begin
			report_mismatch($sformatf("%0d keys never came out", pending_keys.size()));
		end

		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
